// ----- sv/iff_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iff_pkg: shared types and constants for the integer field formatter
// Conversion kinds, flags, radix codes, the descriptor that travels from
// the front end to the back end, and the ASCII constants of the field.
// ----------------------------------------------------------------------------
package iff_pkg;

   typedef enum logic [2:0] {
      KIND_SDEC  = 3'd0,
      KIND_UDEC  = 3'd1,
      KIND_HEXL  = 3'd2,
      KIND_HEXU  = 3'd3,
      KIND_OCT   = 3'd4,
      KIND_PTR   = 3'd5
   } kind_type;

   typedef enum logic [2:0] {
      FLAG_NONE  = 3'd0,
      FLAG_PLUS  = 3'd1,
      FLAG_LEFT  = 3'd2,
      FLAG_SPACE = 3'd3,
      FLAG_ZERO  = 3'd4
   } flag_type;

   typedef enum logic [1:0] {
      RADIX_DEC = 2'd0,
      RADIX_HEX = 2'd1,
      RADIX_OCT = 2'd2
   } radix_type;

   // back end states; emission phases are in field order
   typedef enum logic [3:0] {
      BK_IDLE = 4'd0,
      BK_CONV = 4'd1,
      BK_PRE0 = 4'd2,
      BK_PRE1 = 4'd3,
      BK_LPAD = 4'd4,
      BK_SIGN = 4'd5,
      BK_ZPAD = 4'd6,
      BK_DIG  = 4'd7,
      BK_RPAD = 4'd8
   } back_state_type;

   typedef struct packed {
      radix_type  radix;
      logic       upper;
      logic       prefix;
      flag_type   flag;
      logic       has_sign;
      logic [7:0] sign_char;
      logic [5:0] width;
   } desc_type;

   localparam logic [7:0] CHAR_ZERO      = 8'h30;
   localparam logic [7:0] CHAR_UPPER_OFS = 8'h37;
   localparam logic [7:0] CHAR_LOWER_OFS = 8'h57;
   localparam logic [7:0] CHAR_MINUS     = 8'h2D;
   localparam logic [7:0] CHAR_PLUS      = 8'h2B;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [7:0] CHAR_X         = 8'h78;

endpackage

// ----- sv/iff_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iff_front: request classification
// Decodes conversion kind and flag, takes the magnitude of the value, picks
// the sign character and saturates the field width, then pushes a
// descriptor into the queue.
// ----------------------------------------------------------------------------
module iff_front #(
   parameter int MAX_WIDTH  = 60,
   parameter int VALUE_BITS = 32
) (
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [31:0]            req_value,
   input  logic [2:0]             req_type,
   input  logic [2:0]             req_flag,
   input  logic [5:0]             req_field_width,
   output logic                   push_valid,
   input  logic                   queue_full,
   output logic [VALUE_BITS-1:0]  push_mag,
   output iff_pkg::desc_type      push_desc
);

   logic [VALUE_BITS-1:0] value_bits;
   logic                  is_signed;
   logic                  negative;
   iff_pkg::flag_type     flag_norm;

   assign req_stall  = queue_full;
   assign push_valid = req_valid;
   assign value_bits = req_value[VALUE_BITS-1:0];

   always_comb begin
      push_desc.radix  = iff_pkg::RADIX_DEC;
      push_desc.upper  = 1'b0;
      push_desc.prefix = 1'b0;
      is_signed        = 1'b0;
      case (iff_pkg::kind_type'(req_type))
         iff_pkg::KIND_SDEC: begin
            is_signed = 1'b1;
         end
         iff_pkg::KIND_HEXL: begin
            push_desc.radix = iff_pkg::RADIX_HEX;
         end
         iff_pkg::KIND_HEXU: begin
            push_desc.radix = iff_pkg::RADIX_HEX;
            push_desc.upper = 1'b1;
         end
         iff_pkg::KIND_OCT: begin
            push_desc.radix = iff_pkg::RADIX_OCT;
         end
         iff_pkg::KIND_PTR: begin
            push_desc.radix  = iff_pkg::RADIX_HEX;
            push_desc.prefix = 1'b1;
         end
         default: begin
            // unknown kinds format as unsigned decimal
            push_desc.radix = iff_pkg::RADIX_DEC;
         end
      endcase

      case (iff_pkg::flag_type'(req_flag))
         iff_pkg::FLAG_PLUS:  flag_norm = iff_pkg::FLAG_PLUS;
         iff_pkg::FLAG_LEFT:  flag_norm = iff_pkg::FLAG_LEFT;
         iff_pkg::FLAG_SPACE: flag_norm = iff_pkg::FLAG_SPACE;
         iff_pkg::FLAG_ZERO:  flag_norm = iff_pkg::FLAG_ZERO;
         default:             flag_norm = iff_pkg::FLAG_NONE;
      endcase
      push_desc.flag = flag_norm;

      negative = is_signed && value_bits[VALUE_BITS-1];
      // most negative value wraps to 2^(n-1), which is the right magnitude
      push_mag = negative ? (~value_bits + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : value_bits;

      push_desc.has_sign  = 1'b0;
      push_desc.sign_char = iff_pkg::CHAR_SPACE;
      if (negative) begin
         push_desc.has_sign  = 1'b1;
         push_desc.sign_char = iff_pkg::CHAR_MINUS;
      end else if (is_signed && flag_norm == iff_pkg::FLAG_PLUS) begin
         push_desc.has_sign  = 1'b1;
         push_desc.sign_char = iff_pkg::CHAR_PLUS;
      end else if (is_signed && flag_norm == iff_pkg::FLAG_SPACE) begin
         push_desc.has_sign  = 1'b1;
         push_desc.sign_char = iff_pkg::CHAR_SPACE;
      end

      push_desc.width = (req_field_width > 6'(MAX_WIDTH)) ? 6'(MAX_WIDTH) : req_field_width;
   end

endmodule

// ----- sv/iff_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iff_queue: two-entry descriptor queue
// Decouples request classification from digit conversion and emission.
// ----------------------------------------------------------------------------
module iff_queue #(
   parameter int DATA_W = 54
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  logic [DATA_W-1:0] push_data,
   output logic              full,
   input  logic              pop,
   output logic              not_empty,
   output logic [DATA_W-1:0] pop_data
);

   logic [DATA_W-1:0] mem_ff [2];
   logic              wr_ptr_ff;
   logic              wr_ptr_in;
   logic              rd_ptr_ff;
   logic              rd_ptr_in;
   logic [1:0]        count_ff;
   logic [1:0]        count_in;
   logic              push;
   logic              pop_ok;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign push      = push_valid && !full;
   assign pop_ok    = pop && not_empty;
   assign pop_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop_ok ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop_ok};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- sv/iff_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iff_back: digit conversion and field emission
// Peels one digit per cycle into a small buffer (least significant first),
// then walks the field phases and sends one character per transaction
// through a registered response stage.
// ----------------------------------------------------------------------------
module iff_back #(
   parameter int VALUE_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   output logic                  q_pop,
   input  logic [VALUE_BITS-1:0] q_mag,
   input  iff_pkg::desc_type     q_desc,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [7:0]            rsp_char_out,
   output logic                  rsp_last
);

   localparam int DIG_MAX = (VALUE_BITS + 2) / 3;
   localparam int ND_W    = $clog2(DIG_MAX + 1);
   localparam int IDX_W   = (DIG_MAX > 1) ? $clog2(DIG_MAX) : 1;
   localparam int SHIFT   = VALUE_BITS + 4;
   localparam int PROD_W  = 2 * VALUE_BITS + 5;
   // reciprocal of ten, exact for every VALUE_BITS-bit dividend
   localparam logic [63:0] RECIP = ((64'd1 << SHIFT) + 64'd9) / 64'd10;

   iff_pkg::back_state_type state_ff, state_in;
   logic [VALUE_BITS-1:0]   mag_ff, mag_in;
   iff_pkg::desc_type       desc_ff, desc_in;
   logic [ND_W-1:0]         nd_ff, nd_in;
   logic [5:0]              cnt_ff, cnt_in;
   logic [5:0]              pad_ff, pad_in;
   logic [7:0]              dig_ff [DIG_MAX];
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [7:0]              rsp_char_ff, rsp_char_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic [PROD_W-1:0]       prod;
   logic [VALUE_BITS-1:0]   q10;
   logic [VALUE_BITS-1:0]   r10;
   logic [VALUE_BITS-1:0]   quot;
   logic [3:0]              digit;
   logic [7:0]              digit_char;
   logic [6:0]              body;
   logic [6:0]              width_ext;
   logic [5:0]              pad_calc;
   logic                    out_free;
   logic                    load;
   logic                    phase_done;
   iff_pkg::back_state_type next_phase;
   logic [7:0]              emit_char;

   function automatic iff_pkg::back_state_type pick_phase(
      input logic [3:0]        start,
      input iff_pkg::desc_type d,
      input logic              pad_nz
   );
      iff_pkg::back_state_type r;
      if (start <= 4'(iff_pkg::BK_PRE0) && d.prefix) begin
         r = iff_pkg::BK_PRE0;
      end else if (start <= 4'(iff_pkg::BK_PRE1) && d.prefix) begin
         r = iff_pkg::BK_PRE1;
      end else if (start <= 4'(iff_pkg::BK_LPAD) && pad_nz &&
                   d.flag != iff_pkg::FLAG_LEFT && d.flag != iff_pkg::FLAG_ZERO) begin
         r = iff_pkg::BK_LPAD;
      end else if (start <= 4'(iff_pkg::BK_SIGN) && d.has_sign) begin
         r = iff_pkg::BK_SIGN;
      end else if (start <= 4'(iff_pkg::BK_ZPAD) && pad_nz &&
                   d.flag == iff_pkg::FLAG_ZERO) begin
         r = iff_pkg::BK_ZPAD;
      end else if (start <= 4'(iff_pkg::BK_DIG)) begin
         r = iff_pkg::BK_DIG;
      end else if (start <= 4'(iff_pkg::BK_RPAD) && pad_nz &&
                   d.flag == iff_pkg::FLAG_LEFT) begin
         r = iff_pkg::BK_RPAD;
      end else begin
         r = iff_pkg::BK_IDLE;
      end
      return r;
   endfunction

   function automatic logic [5:0] enter_count(
      input iff_pkg::back_state_type ph,
      input logic [ND_W-1:0]         last_idx,
      input logic [5:0]              pad
   );
      logic [5:0] r;
      if (ph == iff_pkg::BK_DIG) begin
         r = 6'(last_idx);
      end else begin
         r = pad - 6'd1;
      end
      return r;
   endfunction

   // one digit step of the current radix
   always_comb begin
      prod = PROD_W'(mag_ff) * PROD_W'(RECIP[VALUE_BITS:0]);
      q10  = prod[SHIFT +: VALUE_BITS];
      r10  = mag_ff - ((q10 << 3) + (q10 << 1));
      case (desc_ff.radix)
         iff_pkg::RADIX_HEX: begin
            quot  = mag_ff >> 4;
            digit = mag_ff[3:0];
         end
         iff_pkg::RADIX_OCT: begin
            quot  = mag_ff >> 3;
            digit = {1'b0, mag_ff[2:0]};
         end
         default: begin
            quot  = q10;
            digit = r10[3:0];
         end
      endcase
      if (digit <= 4'd9) begin
         digit_char = iff_pkg::CHAR_ZERO + 8'(digit);
      end else begin
         digit_char = 8'(digit) + (desc_ff.upper ? iff_pkg::CHAR_UPPER_OFS :
                                                   iff_pkg::CHAR_LOWER_OFS);
      end
      // digit count after this step is nd_ff + 1
      body      = 7'(nd_ff) + 7'd1 + 7'(desc_ff.has_sign);
      width_ext = 7'(desc_ff.width);
      pad_calc  = (width_ext > body) ? 6'(width_ext - body) : 6'd0;
   end

   always_comb begin
      case (state_ff)
         iff_pkg::BK_PRE0: emit_char = iff_pkg::CHAR_ZERO;
         iff_pkg::BK_PRE1: emit_char = iff_pkg::CHAR_X;
         iff_pkg::BK_SIGN: emit_char = desc_ff.sign_char;
         iff_pkg::BK_ZPAD: emit_char = iff_pkg::CHAR_ZERO;
         iff_pkg::BK_DIG:  emit_char = dig_ff[cnt_ff[IDX_W-1:0]];
         default:          emit_char = iff_pkg::CHAR_SPACE;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      mag_in       = mag_ff;
      desc_in      = desc_ff;
      nd_in        = nd_ff;
      cnt_in       = cnt_ff;
      pad_in       = pad_ff;
      q_pop        = 1'b0;
      load         = 1'b0;
      out_free     = !rsp_valid_ff || !rsp_stall;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      phase_done   = (state_ff == iff_pkg::BK_PRE0) || (state_ff == iff_pkg::BK_PRE1) ||
                     (state_ff == iff_pkg::BK_SIGN) || (cnt_ff == 6'd0);
      next_phase   = pick_phase(4'(state_ff) + 4'd1, desc_ff, pad_ff != 6'd0);

      case (state_ff)
         iff_pkg::BK_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               mag_in   = q_mag;
               desc_in  = q_desc;
               nd_in    = '0;
               state_in = iff_pkg::BK_CONV;
            end
         end
         iff_pkg::BK_CONV: begin
            mag_in = quot;
            nd_in  = nd_ff + ND_W'(1);
            if (quot == '0) begin
               pad_in     = pad_calc;
               next_phase = pick_phase(4'(iff_pkg::BK_PRE0), desc_ff, pad_calc != 6'd0);
               state_in   = next_phase;
               cnt_in     = enter_count(next_phase, nd_ff, pad_calc);
            end
         end
         default: begin
            if (out_free) begin
               load         = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_char_in  = emit_char;
               rsp_last_in  = phase_done && (next_phase == iff_pkg::BK_IDLE);
               if (phase_done) begin
                  state_in = next_phase;
                  cnt_in   = enter_count(next_phase, nd_ff - ND_W'(1), pad_ff);
               end else begin
                  cnt_in = cnt_ff - 6'd1;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= iff_pkg::BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff      <= mag_in;
      desc_ff     <= desc_in;
      nd_ff       <= nd_in;
      cnt_ff      <= cnt_in;
      pad_ff      <= pad_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
      if (state_ff == iff_pkg::BK_CONV) begin
         dig_ff[nd_ff[IDX_W-1:0]] <= digit_char;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_char_out = rsp_char_ff;
   assign rsp_last     = rsp_last_ff;

`ifndef ASSERT_OFF
   a_digit_count: assert property (@(posedge clock) disable iff (reset)
      state_ff != iff_pkg::BK_IDLE |-> 32'(nd_ff) <= DIG_MAX)
      else $error("digit count beyond buffer depth");

   a_digit_index: assert property (@(posedge clock) disable iff (reset)
      state_ff == iff_pkg::BK_DIG |-> 32'(cnt_ff) < 32'(nd_ff))
      else $error("digit index outside converted digits");

   a_pad_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == iff_pkg::BK_LPAD || state_ff == iff_pkg::BK_ZPAD ||
       state_ff == iff_pkg::BK_RPAD) |-> pad_ff != 6'd0)
      else $error("padding phase entered with no padding");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      load && rsp_last_in |=> state_ff == iff_pkg::BK_IDLE)
      else $error("final character sent but field not finished");
`endif

endmodule

// ----- sv/integer_field_formatter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_field_formatter: printf-style integer field, one character out
// Turns one value with conversion kind, flag and minimum width into its
// ASCII field and streams it a character per response transaction.
// ----------------------------------------------------------------------------
// A request is classified on arrival and parked in a two-entry queue, so up
// to two further requests are taken while a field is still being sent. The
// back end then pops the queue in its idle state, converts one digit per
// cycle (up to 11 for a 32-bit octal value, 10 decimal, 8 hex) with the
// first phase picked in the last digit step, and then sends the field (up
// to 62 characters) one character per cycle through the single response
// register while the response side does not stall. The back end takes a
// new request only once the last character of the previous field is sent.
// ----------------------------------------------------------------------------
module integer_field_formatter #(
   parameter int MAX_WIDTH  = 60,
   parameter int VALUE_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_value,
   input  logic [2:0]  req_type,
   input  logic [2:0]  req_flag,
   input  logic [5:0]  req_field_width,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_char_out,
   output logic        rsp_last
);

   localparam int DESC_W = $bits(iff_pkg::desc_type);
   localparam int DATA_W = VALUE_BITS + DESC_W;

   logic                  push_valid;
   logic                  queue_full;
   logic [VALUE_BITS-1:0] push_mag;
   iff_pkg::desc_type     push_desc;
   logic                  q_pop;
   logic                  q_valid;
   logic [DATA_W-1:0]     q_data;
   logic [VALUE_BITS-1:0] q_mag;
   iff_pkg::desc_type     q_desc;

   iff_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .VALUE_BITS (VALUE_BITS)
   ) u_front (
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_value       (req_value),
      .req_type        (req_type),
      .req_flag        (req_flag),
      .req_field_width (req_field_width),
      .push_valid      (push_valid),
      .queue_full      (queue_full),
      .push_mag        (push_mag),
      .push_desc       (push_desc)
   );

   iff_queue #(
      .DATA_W (DATA_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  ({push_mag, push_desc}),
      .full       (queue_full),
      .pop        (q_pop),
      .not_empty  (q_valid),
      .pop_data   (q_data)
   );

   assign q_mag  = q_data[DATA_W-1 -: VALUE_BITS];
   assign q_desc = iff_pkg::desc_type'(q_data[DESC_W-1:0]);

   iff_back #(
      .VALUE_BITS (VALUE_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (q_valid),
      .q_pop        (q_pop),
      .q_mag        (q_mag),
      .q_desc       (q_desc),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_char_out (rsp_char_out),
      .rsp_last     (rsp_last)
   );

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the integer field formatter
// Drives every conversion kind and flag at widths 0 to 63 and predicts the
// ASCII field of each one. Every character that comes out is checked against
// that prediction, including where the field ends. Both sides idle at random,
// and the response side once holds off long enough to back up the request side.
// ----------------------------------------------------------------------------
module tb;

   localparam int CYCLE_LIMIT  = 1000000;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 100;
   localparam int RANDOM_ITEMS = 280;
   localparam int CALM_ITEMS   = 40;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } field_char_type;

   class field_scoreboard;
      localparam int MAX_FIELD = 60;
      field_char_type pending_chars[$];
      int             errors;
      int             fields_noted;
      int             chars_checked;

      task report(input string msg);
         $display("mismatch: %s", msg);
         errors++;
      endtask

      // builds the characters of one accepted field and queues them in order
      function void note_request(input logic [31:0] value, input logic [2:0] kind,
                                 input logic [2:0] flag, input logic [5:0] width);
         logic [32:0]       mag;
         logic [7:0]        digs[$];
         logic [7:0]        line[$];
         logic [7:0]        sign_ch;
         int unsigned       radix, d, pad, w, body;
         bit                upper, ptr, signed_kind, has_sign;
         iff_pkg::flag_type fl;

         fl = (flag > iff_pkg::FLAG_ZERO) ? iff_pkg::FLAG_NONE : iff_pkg::flag_type'(flag);
         radix = 10;
         upper = 1'b0;
         ptr = 1'b0;
         signed_kind = 1'b0;
         case (kind)
            iff_pkg::KIND_SDEC: signed_kind = 1'b1;
            iff_pkg::KIND_HEXL: radix = 16;
            iff_pkg::KIND_HEXU: begin
               radix = 16;
               upper = 1'b1;
            end
            iff_pkg::KIND_OCT: radix = 8;
            iff_pkg::KIND_PTR: begin
               radix = 16;
               ptr = 1'b1;
            end
            default: ;
         endcase

         mag = {1'b0, value};
         has_sign = 1'b0;
         sign_ch = iff_pkg::CHAR_SPACE;
         if (signed_kind) begin
            if (value[31]) begin
               // most negative value comes out as magnitude 2^31
               mag = 33'h1_0000_0000 - {1'b0, value};
               has_sign = 1'b1;
               sign_ch = iff_pkg::CHAR_MINUS;
            end else if (fl == iff_pkg::FLAG_PLUS) begin
               has_sign = 1'b1;
               sign_ch = iff_pkg::CHAR_PLUS;
            end else if (fl == iff_pkg::FLAG_SPACE) begin
               has_sign = 1'b1;
               sign_ch = iff_pkg::CHAR_SPACE;
            end
         end

         // least significant digit first
         do begin
            d = 32'(mag % radix);
            mag = mag / radix;
            if (d <= 9)
               digs.push_back(iff_pkg::CHAR_ZERO + 8'(d));
            else
               digs.push_back((upper ? iff_pkg::CHAR_UPPER_OFS : iff_pkg::CHAR_LOWER_OFS)
                              + 8'(d));
         end while (mag != 0);

         w = (width > MAX_FIELD) ? MAX_FIELD : width;
         body = digs.size() + (has_sign ? 1 : 0);
         pad = (w > body) ? w - body : 0;

         if (ptr) begin
            line.push_back(iff_pkg::CHAR_ZERO);
            line.push_back(iff_pkg::CHAR_X);
         end
         case (fl)
            iff_pkg::FLAG_LEFT: begin
               if (has_sign)
                  line.push_back(sign_ch);
               for (int i = digs.size() - 1; i >= 0; i--)
                  line.push_back(digs[i]);
               repeat (pad) line.push_back(iff_pkg::CHAR_SPACE);
            end
            iff_pkg::FLAG_ZERO: begin
               if (has_sign)
                  line.push_back(sign_ch);
               repeat (pad) line.push_back(iff_pkg::CHAR_ZERO);
               for (int i = digs.size() - 1; i >= 0; i--)
                  line.push_back(digs[i]);
            end
            default: begin
               repeat (pad) line.push_back(iff_pkg::CHAR_SPACE);
               if (has_sign)
                  line.push_back(sign_ch);
               for (int i = digs.size() - 1; i >= 0; i--)
                  line.push_back(digs[i]);
            end
         endcase

         foreach (line[i])
            pending_chars.push_back('{ch: line[i], last: (i == line.size() - 1)});
         fields_noted++;
      endfunction

      task check_char(input logic [7:0] ch, input logic last);
         field_char_type want;
         if (pending_chars.size() == 0) begin
            report($sformatf("character 0x%02h arrived with no field pending", ch));
         end else begin
            want = pending_chars.pop_front();
            if (ch !== want.ch)
               report($sformatf("char %0d: got 0x%02h, want 0x%02h",
                                chars_checked, ch, want.ch));
            if (last !== want.last)
               report($sformatf("char %0d: last got %b, want %b",
                                chars_checked, last, want.last));
         end
         chars_checked++;
      endtask

      function int pending();
         return pending_chars.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [31:0] req_value;
   logic [2:0]  req_type;
   logic [2:0]  req_flag;
   logic [5:0]  req_field_width;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_char_out;
   logic        rsp_last;

   field_scoreboard sb = new();
   bit  calm;
   bit  hold_rsp;
   int  long_holds;
   int  cycles;

   integer_field_formatter dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_value       (req_value),
      .req_type        (req_type),
      .req_flag        (req_flag),
      .req_field_width (req_field_width),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_char_out    (rsp_char_out),
      .rsp_last        (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d characters still pending",
                  cycles, sb.pending());
         $display("FAILURE");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_char(rsp_char_out, rsp_last);
   end

   // response side: random stall bursts, one long hold on request
   initial begin
      rsp_stall = 1'b0;
      @(negedge clock iff !reset);
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            long_holds++;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            rsp_stall <= 1'b0;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 10)) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_request(input logic [31:0] v, input logic [2:0] k,
                               input logic [2:0] f, input logic [5:0] w);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_value       <= v;
      req_type        <= k;
      req_flag        <= f;
      req_field_width <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(v, k, f, w);
      @(negedge clock);
   endtask

   task automatic send_random();
      logic [31:0] v;
      logic [2:0]  k, f;
      logic [5:0]  w;
      case ($urandom_range(0, 5))
         0: v = $urandom;
         1: v = $urandom_range(0, 99);
         2: v = -$urandom_range(1, 1000);
         3: begin
            case ($urandom_range(0, 3))
               0: v = 32'h8000_0000;
               1: v = 32'hFFFF_FFFF;
               2: v = 32'h7FFF_FFFF;
               default: v = 32'h0;
            endcase
         end
         default: v = $urandom >> $urandom_range(0, 31);
      endcase
      if ($urandom_range(0, 9) == 0) begin
         // malformed codes and oversized widths
         k = 3'($urandom_range(0, 7));
         f = 3'($urandom_range(0, 7));
         w = 6'($urandom_range(0, 63));
      end else begin
         k = 3'($urandom_range(iff_pkg::KIND_SDEC, iff_pkg::KIND_PTR));
         f = 3'($urandom_range(iff_pkg::FLAG_NONE, iff_pkg::FLAG_ZERO));
         w = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(0, 60)) :
                                           6'($urandom_range(0, 16));
      end
      send_request(v, k, f, w);
   endtask

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_value       = '0;
      req_type        = '0;
      req_flag        = '0;
      req_field_width = '0;
      calm            = 1'b0;
      hold_rsp        = 1'b0;
      long_holds      = 0;
      cycles          = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // all-ones under every kind, zero as signed decimal and as pointer
      send_request(32'h0, iff_pkg::KIND_SDEC, iff_pkg::FLAG_NONE, 6'd0);
      send_request(32'h0, iff_pkg::KIND_PTR, iff_pkg::FLAG_NONE, 6'd0);
      send_request(32'hFFFF_FFFF, iff_pkg::KIND_SDEC, iff_pkg::FLAG_NONE, 6'd0);
      send_request(32'hFFFF_FFFF, iff_pkg::KIND_UDEC, iff_pkg::FLAG_NONE, 6'd0);
      send_request(32'hFFFF_FFFF, iff_pkg::KIND_HEXL, iff_pkg::FLAG_NONE, 6'd0);
      send_request(32'hFFFF_FFFF, iff_pkg::KIND_HEXU, iff_pkg::FLAG_NONE, 6'd0);
      send_request(32'hFFFF_FFFF, iff_pkg::KIND_OCT, iff_pkg::FLAG_NONE, 6'd0);
      send_request(32'hFFFF_FFFF, iff_pkg::KIND_PTR, iff_pkg::FLAG_NONE, 6'd0);
      // most negative and most positive signed values
      send_request(32'h8000_0000, iff_pkg::KIND_SDEC, iff_pkg::FLAG_NONE, 6'd0);
      send_request(32'h8000_0000, iff_pkg::KIND_SDEC, iff_pkg::FLAG_ZERO, 6'd15);
      send_request(32'h7FFF_FFFF, iff_pkg::KIND_SDEC, iff_pkg::FLAG_PLUS, 6'd12);
      // each flag, sign placement around padding
      send_request(32'd42, iff_pkg::KIND_SDEC, iff_pkg::FLAG_SPACE, 6'd6);
      send_request(-32'd42, iff_pkg::KIND_SDEC, iff_pkg::FLAG_LEFT, 6'd20);
      send_request(32'd42, iff_pkg::KIND_SDEC, iff_pkg::FLAG_PLUS, 6'd1);
      send_request(-32'd7, iff_pkg::KIND_SDEC, iff_pkg::FLAG_ZERO, 6'd5);
      send_request(32'hDEAD_BEEF, iff_pkg::KIND_PTR, iff_pkg::FLAG_ZERO, 6'd12);
      send_request(32'hDEAD_BEEF, iff_pkg::KIND_HEXU, iff_pkg::FLAG_LEFT, 6'd60);
      send_request(32'd5, iff_pkg::KIND_UDEC, iff_pkg::FLAG_PLUS, 6'd4);
      // width saturation, unknown kinds and flags
      send_request(32'h8000_0000, iff_pkg::KIND_SDEC, iff_pkg::FLAG_LEFT, 6'd63);
      send_request(32'h0, iff_pkg::KIND_PTR, iff_pkg::FLAG_NONE, 6'd61);
      send_request(32'd1234, 3'd6, iff_pkg::FLAG_NONE, 6'd8);
      send_request(-32'd1234, 3'd7, 3'd5, 6'd8);
      send_request(-32'd9, iff_pkg::KIND_SDEC, 3'd6, 6'd4);
      send_request(32'd9, iff_pkg::KIND_SDEC, 3'd7, 6'd4);
      send_request(32'o17, iff_pkg::KIND_OCT, iff_pkg::FLAG_ZERO, 6'd60);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == 40)
            hold_rsp = 1'b1;
         if (i == RANDOM_ITEMS - CALM_ITEMS)
            calm = 1'b1;
         send_random();
      end
      req_valid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d fields and %0d characters over all kinds, flags and widths,",
               sb.fields_noted, sb.chars_checked);
      $display("with random idling on both sides and %0d long response hold(s)", long_holds);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("%0d mismatches", sb.errors);
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ----- files.f -----
sv/iff_pkg.sv
sv/iff_front.sv
sv/iff_queue.sv
sv/iff_back.sv
sv/integer_field_formatter.sv
dv/tb.sv
